// ===== hw/rtl/skt_pkg.sv =====
// skt_pkg: shared types and constants for the sorted key total table
// field widths, status codes, controller states and the per-cell command struct
// depends on nothing
package skt_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 64;
  localparam int KEY_BITS_DEFAULT    = 64;

  localparam int KEY_W    = 64;
  localparam int AMOUNT_W = 32;
  localparam int INDEX_W  = 6;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 2;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_MERGED   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_READ     = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RESOLVE,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic cmp;
    logic shift;
    logic load;
    logic merge;
  } cell_cmd_t;

endpackage

// ===== hw/rtl/skt_if.sv =====
// skt_request_if and skt_result_if: valid/ready channels of the table
// widths come from skt_pkg
interface skt_request_if;
  logic                             valid;
  logic                             ready;
  logic                             func;
  logic [skt_pkg::KEY_W-1:0]        key;
  logic signed [skt_pkg::AMOUNT_W-1:0] amount;
  logic [skt_pkg::INDEX_W-1:0]      index;

  modport source (output valid, func, key, amount, index, input ready);
  modport sink   (input valid, func, key, amount, index, output ready);
endinterface

interface skt_result_if;
  logic                             valid;
  logic                             ready;
  logic [skt_pkg::STATUS_W-1:0]     status;
  logic [skt_pkg::POS_W-1:0]        position;
  logic [skt_pkg::POS_W-1:0]        entry_count;
  logic [skt_pkg::KEY_W-1:0]        key_out;
  logic signed [skt_pkg::AMOUNT_W-1:0] total_out;
  logic                             valid_res;

  modport source (output valid, status, position, entry_count, key_out, total_out,
                  valid_res, input ready);
  modport sink   (input valid, status, position, entry_count, key_out, total_out,
                  valid_res, output ready);
endinterface

// ===== hw/rtl/skt_cell.sv =====
// skt_cell: one table slot holding a key and its total
// compares against the broadcast key, takes its left neighbor on a shift
// depends on skt_pkg
module skt_cell #(
  parameter int KEY_BITS = skt_pkg::KEY_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  skt_pkg::cell_cmd_t                  cmd,
  input  logic                                occ,
  input  logic [KEY_BITS-1:0]                 cmp_key,
  input  logic [KEY_BITS-1:0]                 left_key,
  input  logic signed [skt_pkg::AMOUNT_W-1:0] left_total,
  input  logic [KEY_BITS-1:0]                 wr_key,
  input  logic signed [skt_pkg::AMOUNT_W-1:0] wr_total,
  output logic [KEY_BITS-1:0]                 key,
  output logic signed [skt_pkg::AMOUNT_W-1:0] total,
  output logic                                lt,
  output logic                                eq
);

  always_ff @(posedge clk) begin
    if (rst) begin
      lt <= 1'b0;
      eq <= 1'b0;
    end else if (cmd.cmp) begin
      lt <= occ && (key < cmp_key);
      eq <= occ && (key == cmp_key);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      key   <= left_key;
      total <= left_total;
    end else if (cmd.load) begin
      key   <= wr_key;
      total <= wr_total;
    end else if (cmd.merge) begin
      total <= wr_total;
    end
  end

endmodule

// ===== hw/rtl/sorted_key_total_table_top.sv =====
// sorted_key_total_table_top: sorted key/total table built as a row of cells
// depends on skt_pkg, skt_if (request/result channels) and skt_cell
//
// Each request passes through the states IDLE, in which it is accepted and
// latched; SEARCH, in which every cell compares its key against the request
// key in parallel; RESOLVE, which encodes the insertion position and forms the
// saturated sum or read data; and COMMIT, in which the cells merge, shift up by
// one toward their right neighbor and place the new key, and the result is
// registered. A new request is accepted once the previous one has committed;
// the result register holds its answer until taken, and a result still waiting
// only stalls the commit of the following request.
// Table contents are undefined after reset; the entry count, state, result
// valid flag and cell compare flags are cleared.
module sorted_key_total_table_top #(
  parameter int TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEFAULT,
  parameter int KEY_BITS    = skt_pkg::KEY_BITS_DEFAULT
) (
  input logic              clk,
  input logic              rst,
  skt_request_if.sink      request,
  skt_result_if.source     result
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  skt_pkg::state_t state, state_next;

  logic                                req_func;
  logic [KEY_BITS-1:0]                 req_key;
  logic signed [skt_pkg::AMOUNT_W-1:0] req_amount;
  logic [skt_pkg::INDEX_W-1:0]         req_index;

  logic [CW-1:0] count;

  logic [KEY_BITS-1:0]                 cell_key   [TABLE_DEPTH];
  logic signed [skt_pkg::AMOUNT_W-1:0] cell_total [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]              cell_lt;
  logic [TABLE_DEPTH-1:0]              cell_eq;
  skt_pkg::cell_cmd_t                  cell_cmd   [TABLE_DEPTH];

  logic [CW-1:0]                       pos_c, pos;
  logic                                hit_c, hit;
  logic signed [skt_pkg::AMOUNT_W-1:0] hit_total_c;
  logic signed [skt_pkg::AMOUNT_W-1:0] sum;
  logic signed [skt_pkg::AMOUNT_W:0]   wide_sum_c;
  logic signed [skt_pkg::AMOUNT_W-1:0] sum_c;
  logic                                rd_valid_c, rd_valid;
  logic [KEY_BITS-1:0]                 rd_key_c, rd_key;
  logic signed [skt_pkg::AMOUNT_W-1:0] rd_total_c, rd_total;

  logic accept;
  logic commit;
  logic full;
  logic is_insert;
  logic signed [skt_pkg::AMOUNT_W-1:0] wr_total;

  assign accept    = request.valid && request.ready;
  assign commit    = (state == skt_pkg::ST_COMMIT) && (!result.valid || result.ready);
  assign full      = (32'(count) >= TABLE_DEPTH);
  assign is_insert = (req_func == skt_pkg::FUNC_INSERT) && !hit && !full;
  assign wr_total  = hit ? sum : req_amount;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= skt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    request.ready = 1'b0;
    case (state)
      skt_pkg::ST_IDLE: begin
        request.ready = !rst;
        if (request.valid) state_next = skt_pkg::ST_SEARCH;
      end
      skt_pkg::ST_SEARCH:  state_next = skt_pkg::ST_RESOLVE;
      skt_pkg::ST_RESOLVE: state_next = skt_pkg::ST_COMMIT;
      skt_pkg::ST_COMMIT: begin
        if (commit) state_next = skt_pkg::ST_IDLE;
      end
      default: state_next = skt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_func   <= request.func;
      req_key    <= request.key[KEY_BITS-1:0];
      req_amount <= request.amount;
      req_index  <= request.index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (commit && is_insert) begin
      count <= count + CW'(1);
    end
  end

  // position from the thermometer of less-than flags, one-hot hit and read selects
  always_comb begin
    pos_c       = '0;
    hit_c       = 1'b0;
    hit_total_c = '0;
    rd_key_c    = '0;
    rd_total_c  = '0;
    rd_valid_c  = (32'(req_index) < 32'(count));
    for (int i = 0; i <= TABLE_DEPTH; i++) begin
      logic below, here;
      below = (i == 0) ? 1'b1 : cell_lt[(i == 0) ? 0 : i - 1];
      here  = (i == TABLE_DEPTH) ? 1'b0 : cell_lt[(i == TABLE_DEPTH) ? 0 : i];
      if (below && !here) pos_c = pos_c | CW'(i);
    end
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_c = hit_c | cell_eq[i];
      if (cell_eq[i]) hit_total_c = hit_total_c | cell_total[i];
      if (rd_valid_c && (32'(req_index) == i)) begin
        rd_key_c   = rd_key_c | cell_key[i];
        rd_total_c = rd_total_c | cell_total[i];
      end
    end
  end

  assign wide_sum_c = {hit_total_c[skt_pkg::AMOUNT_W-1], hit_total_c}
                    + {req_amount[skt_pkg::AMOUNT_W-1], req_amount};

  always_comb begin
    sum_c = wide_sum_c[skt_pkg::AMOUNT_W-1:0];
    if (wide_sum_c[skt_pkg::AMOUNT_W] != wide_sum_c[skt_pkg::AMOUNT_W-1]) begin
      sum_c = wide_sum_c[skt_pkg::AMOUNT_W] ? {1'b1, {(skt_pkg::AMOUNT_W-1){1'b0}}}
                                            : {1'b0, {(skt_pkg::AMOUNT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (state == skt_pkg::ST_RESOLVE) begin
      pos      <= pos_c;
      hit      <= hit_c;
      sum      <= sum_c;
      rd_valid <= rd_valid_c;
      rd_key   <= rd_key_c;
      rd_total <= rd_total_c;
    end
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    always_comb begin
      cell_cmd[g].cmp   = (state == skt_pkg::ST_SEARCH);
      cell_cmd[g].shift = commit && is_insert && (g > 0) && (32'(pos) < g)
                          && (g <= 32'(count));
      cell_cmd[g].load  = commit && is_insert && (32'(pos) == g);
      cell_cmd[g].merge = commit && (req_func == skt_pkg::FUNC_INSERT) && hit && cell_eq[g];
    end

    skt_cell #(
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cell_cmd[g]),
      .occ        (32'(count) > g),
      .cmp_key    (req_key),
      .left_key   (cell_key[(g == 0) ? 0 : g - 1]),
      .left_total (cell_total[(g == 0) ? 0 : g - 1]),
      .wr_key     (req_key),
      .wr_total   (wr_total),
      .key        (cell_key[g]),
      .total      (cell_total[g]),
      .lt         (cell_lt[g]),
      .eq         (cell_eq[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (commit) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      result.entry_count <= skt_pkg::POS_W'(is_insert ? count + CW'(1) : count);
      if (req_func == skt_pkg::FUNC_READ) begin
        result.status    <= skt_pkg::STATUS_READ;
        result.position  <= skt_pkg::POS_W'(req_index);
        result.key_out   <= skt_pkg::KEY_W'(rd_key);
        result.total_out <= rd_total;
        result.valid_res <= rd_valid;
      end else if (hit) begin
        result.status    <= skt_pkg::STATUS_MERGED;
        result.position  <= skt_pkg::POS_W'(pos);
        result.key_out   <= skt_pkg::KEY_W'(req_key);
        result.total_out <= sum;
        result.valid_res <= 1'b1;
      end else if (full) begin
        result.status    <= skt_pkg::STATUS_DROPPED;
        result.position  <= skt_pkg::POS_W'(pos);
        result.key_out   <= skt_pkg::KEY_W'(req_key);
        result.total_out <= '0;
        result.valid_res <= 1'b0;
      end else begin
        result.status    <= skt_pkg::STATUS_INSERTED;
        result.position  <= skt_pkg::POS_W'(pos);
        result.key_out   <= skt_pkg::KEY_W'(req_key);
        result.total_out <= req_amount;
        result.valid_res <= 1'b1;
      end
    end
  end

endmodule
